@@ rtl/core/pdcc_pkg.sv @@
package pdcc_pkg;

  typedef enum logic [4:0] {
    OP_IDLE,
    OP_TAKE_FIRST,
    OP_TAKE_NEXT,
    OP_OPEN_CLOSE,
    OP_DOT_X,
    OP_DOT_Y,
    OP_MAG_X,
    OP_MAG_Y,
    OP_SQ_LO,
    OP_SQ_MID,
    OP_SQ_HI,
    OP_PR_LL,
    OP_PR_LH,
    OP_PR_HL,
    OP_PR_HH,
    OP_DECIDE,
    OP_EMIT
  } op_t;

endpackage

@@ rtl/core/pdcc_ctrl.sv @@
module pdcc_ctrl (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  input  logic           in_last_point,
  output logic           in_stall,
  output logic           out_valid,
  input  logic           out_stall,
  output pdcc_pkg::op_t  op
);

  typedef enum logic [4:0] {
    S_IDLE,
    S_OPEN_CLOSE,
    S_DOT_X,
    S_DOT_Y,
    S_MAG_X,
    S_MAG_Y,
    S_SQ_LO,
    S_SQ_MID,
    S_SQ_HI,
    S_PR_LL,
    S_PR_LH,
    S_PR_HL,
    S_PR_HH,
    S_DRAIN,
    S_DECIDE,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;
  logic   inside_r, inside_nxt;
  logic   last_r, last_nxt;
  logic   closing_r, closing_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    inside_nxt    = inside_r;
    last_nxt      = last_r;
    closing_nxt   = closing_r;
    out_valid_nxt = out_valid_r & out_stall;
    op            = pdcc_pkg::OP_IDLE;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          last_nxt    = in_last_point;
          closing_nxt = 1'b0;
          inside_nxt  = 1'b1;
          if (inside_r) begin
            op        = pdcc_pkg::OP_TAKE_NEXT;
            state_nxt = S_DOT_X;
          end else begin
            op        = pdcc_pkg::OP_TAKE_FIRST;
            state_nxt = in_last_point ? S_OPEN_CLOSE : S_IDLE;
          end
        end
      end
      S_OPEN_CLOSE: begin
        op          = pdcc_pkg::OP_OPEN_CLOSE;
        closing_nxt = 1'b1;
        state_nxt   = S_DOT_X;
      end
      S_DOT_X: begin
        op        = pdcc_pkg::OP_DOT_X;
        state_nxt = S_DOT_Y;
      end
      S_DOT_Y: begin
        op        = pdcc_pkg::OP_DOT_Y;
        state_nxt = S_MAG_X;
      end
      S_MAG_X: begin
        op        = pdcc_pkg::OP_MAG_X;
        state_nxt = S_MAG_Y;
      end
      S_MAG_Y: begin
        op        = pdcc_pkg::OP_MAG_Y;
        state_nxt = S_SQ_LO;
      end
      S_SQ_LO: begin
        op        = pdcc_pkg::OP_SQ_LO;
        state_nxt = S_SQ_MID;
      end
      S_SQ_MID: begin
        op        = pdcc_pkg::OP_SQ_MID;
        state_nxt = S_SQ_HI;
      end
      S_SQ_HI: begin
        op        = pdcc_pkg::OP_SQ_HI;
        state_nxt = S_PR_LL;
      end
      S_PR_LL: begin
        op        = pdcc_pkg::OP_PR_LL;
        state_nxt = S_PR_LH;
      end
      S_PR_LH: begin
        op        = pdcc_pkg::OP_PR_LH;
        state_nxt = S_PR_HL;
      end
      S_PR_HL: begin
        op        = pdcc_pkg::OP_PR_HL;
        state_nxt = S_PR_HH;
      end
      S_PR_HH: begin
        op        = pdcc_pkg::OP_PR_HH;
        state_nxt = S_DRAIN;
      end
      S_DRAIN: begin
        state_nxt = S_DECIDE;
      end
      S_DECIDE: begin
        op = pdcc_pkg::OP_DECIDE;
        if (closing_r) begin
          state_nxt = S_EMIT;
        end else if (last_r) begin
          state_nxt = S_OPEN_CLOSE;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          op            = pdcc_pkg::OP_EMIT;
          out_valid_nxt = 1'b1;
          inside_nxt    = 1'b0;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      inside_r    <= 1'b0;
      last_r      <= 1'b0;
      closing_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      inside_r    <= inside_nxt;
      last_r      <= last_nxt;
      closing_r   <= closing_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

@@ rtl/core/pdcc_dp.sv @@
module pdcc_dp #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pdcc_pkg::op_t                op,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  output logic        [COUNT_BITS-1:0] out_change_count
);

  localparam int CW  = COORD_BITS;
  localparam int DW  = CW + 1;
  localparam int MW  = CW + 2;
  localparam int PW  = 2 * MW;
  localparam int SW  = 2 * CW + 3;
  localparam int QW  = 2 * CW + 2;
  localparam int AW  = 4 * CW + 6;
  localparam int H   = CW + 1;

  logic signed [CW-1:0]         first_x_r, first_y_r, prev_x_r, prev_y_r;
  logic signed [DW-1:0]         dx_r, dy_r, kx_r, ky_r;
  logic signed [SW-1:0]         dot_r, dot_neg;
  logic        [QW-1:0]         dot_abs_r, dmag_r, kmag_r;
  logic signed [AW-1:0]         acc_r, prod_ext;
  logic signed [PW-1:0]         prod_r, prod_w;
  logic signed [MW-1:0]         mul_a, mul_b;
  pdcc_pkg::op_t                acc_op_r;
  logic        [COUNT_BITS-1:0] count_r, out_count_r;
  logic                         counts;

  assign out_change_count = out_count_r;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (op)
      pdcc_pkg::OP_DOT_X: begin
        mul_a = MW'(dx_r);
        mul_b = MW'(kx_r);
      end
      pdcc_pkg::OP_DOT_Y: begin
        mul_a = MW'(dy_r);
        mul_b = MW'(ky_r);
      end
      pdcc_pkg::OP_MAG_X: begin
        mul_a = MW'(dx_r);
        mul_b = MW'(dx_r);
      end
      pdcc_pkg::OP_MAG_Y: begin
        mul_a = MW'(dy_r);
        mul_b = MW'(dy_r);
      end
      pdcc_pkg::OP_SQ_LO: begin
        mul_a = $signed({1'b0, dot_abs_r[H-1:0]});
        mul_b = $signed({1'b0, dot_abs_r[H-1:0]});
      end
      pdcc_pkg::OP_SQ_MID: begin
        mul_a = $signed({1'b0, dot_abs_r[QW-1:H]});
        mul_b = $signed({1'b0, dot_abs_r[H-1:0]});
      end
      pdcc_pkg::OP_SQ_HI: begin
        mul_a = $signed({1'b0, dot_abs_r[QW-1:H]});
        mul_b = $signed({1'b0, dot_abs_r[QW-1:H]});
      end
      pdcc_pkg::OP_PR_LL: begin
        mul_a = $signed({1'b0, dmag_r[H-1:0]});
        mul_b = $signed({1'b0, kmag_r[H-1:0]});
      end
      pdcc_pkg::OP_PR_LH: begin
        mul_a = $signed({1'b0, dmag_r[H-1:0]});
        mul_b = $signed({1'b0, kmag_r[QW-1:H]});
      end
      pdcc_pkg::OP_PR_HL: begin
        mul_a = $signed({1'b0, dmag_r[QW-1:H]});
        mul_b = $signed({1'b0, kmag_r[H-1:0]});
      end
      pdcc_pkg::OP_PR_HH: begin
        mul_a = $signed({1'b0, dmag_r[QW-1:H]});
        mul_b = $signed({1'b0, kmag_r[QW-1:H]});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod_w   = PW'(mul_a) * PW'(mul_b);
  assign prod_ext = AW'(prod_r);
  assign dot_neg  = -dot_r;
  assign counts   = (dmag_r == '0) || (kmag_r == '0) || (!acc_r[AW-1] && (acc_r != '0));

  always_ff @(posedge clk) begin
    prod_r    <= prod_w;
    dot_abs_r <= dot_r[SW-1] ? dot_neg[QW-1:0] : dot_r[QW-1:0];

    if (op == pdcc_pkg::OP_TAKE_FIRST) begin
      first_x_r <= in_point_x;
      first_y_r <= in_point_y;
      prev_x_r  <= in_point_x;
      prev_y_r  <= in_point_y;
    end else if (op == pdcc_pkg::OP_TAKE_NEXT) begin
      dx_r     <= DW'(in_point_x) - DW'(prev_x_r);
      dy_r     <= DW'(in_point_y) - DW'(prev_y_r);
      prev_x_r <= in_point_x;
      prev_y_r <= in_point_y;
    end else if (op == pdcc_pkg::OP_OPEN_CLOSE) begin
      dx_r <= DW'(first_x_r) - DW'(prev_x_r);
      dy_r <= DW'(first_y_r) - DW'(prev_y_r);
    end

    if (op == pdcc_pkg::OP_TAKE_NEXT || op == pdcc_pkg::OP_OPEN_CLOSE) begin
      dot_r  <= '0;
      dmag_r <= '0;
      acc_r  <= '0;
    end else begin
      case (acc_op_r)
        pdcc_pkg::OP_DOT_X, pdcc_pkg::OP_DOT_Y: begin
          dot_r <= dot_r + prod_r[SW-1:0];
        end
        pdcc_pkg::OP_MAG_X, pdcc_pkg::OP_MAG_Y: begin
          dmag_r <= dmag_r + prod_r[QW-1:0];
        end
        pdcc_pkg::OP_SQ_LO: begin
          acc_r <= acc_r - (prod_ext <<< 2);
        end
        pdcc_pkg::OP_SQ_MID: begin
          acc_r <= acc_r - (prod_ext <<< (H + 3));
        end
        pdcc_pkg::OP_SQ_HI: begin
          acc_r <= acc_r - (prod_ext <<< (2 * H + 2));
        end
        pdcc_pkg::OP_PR_LL: begin
          acc_r <= acc_r + prod_ext;
        end
        pdcc_pkg::OP_PR_LH, pdcc_pkg::OP_PR_HL: begin
          acc_r <= acc_r + (prod_ext <<< H);
        end
        pdcc_pkg::OP_PR_HH: begin
          acc_r <= acc_r + (prod_ext <<< (2 * H));
        end
        default: begin
          acc_r <= acc_r;
        end
      endcase
    end

    if (op == pdcc_pkg::OP_EMIT) begin
      out_count_r <= count_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_op_r <= pdcc_pkg::OP_IDLE;
      kx_r     <= '0;
      ky_r     <= '0;
      kmag_r   <= '0;
      count_r  <= '0;
    end else begin
      acc_op_r <= op;
      if (op == pdcc_pkg::OP_DECIDE && counts) begin
        kx_r   <= dx_r;
        ky_r   <= dy_r;
        kmag_r <= dmag_r;
        if (count_r != '1) begin
          count_r <= count_r + COUNT_BITS'(1);
        end
      end else if (op == pdcc_pkg::OP_EMIT) begin
        kx_r    <= '0;
        ky_r    <= '0;
        kmag_r  <= '0;
        count_r <= '0;
      end
    end
  end

endmodule

@@ rtl/core/polyline_direction_change_counter.sv @@
// A first vertex that is not last is only stored; every later vertex has its segment worked
// on the one shared multiplier (11 products, one drain, one decision).
// A last vertex that is not first takes its segment, the closing segment, then an output step that waits on out_stall.
// The count appears on the output in the cycle after that step; a new beat is taken while it waits there.
// Synchronous active-low reset clears the control state, the kept direction and the count.
module polyline_direction_change_counter #(
  parameter int COORD_BITS = 16,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [COORD_BITS-1:0] in_point_x,
  input  logic signed [COORD_BITS-1:0] in_point_y,
  input  logic                         in_last_point,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic        [COUNT_BITS-1:0] out_change_count
);

  pdcc_pkg::op_t op;

  pdcc_ctrl u_ctrl (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_last_point (in_last_point),
    .in_stall      (in_stall),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .op            (op)
  );

  pdcc_dp #(
    .COORD_BITS (COORD_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .op               (op),
    .in_point_x       (in_point_x),
    .in_point_y       (in_point_y),
    .out_change_count (out_change_count)
  );

endmodule
